// ----- rtl/sha1_message_digest_defines.svh -----
// Assertion macros for the SHA-1 digest block.
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH
`ifndef SYNTH
`define SHA1_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHA1_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SHA1_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/sha1_pkg.sv -----
// Shared types and constants of the SHA-1 digest block.
package sha1_pkg;
    localparam logic [31:0] H_INIT [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                          32'h10325476, 32'hC3D2E1F0};
    localparam int QUEUE_DEPTH = 4;

    // One word moved from the front part to the back part.
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       msg_end;
    } sha1_item_t;

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        begin
            if (r < 7'd20)
                k = 32'h5A827999;
            else if (r < 7'd40)
                k = 32'h6ED9EBA1;
            else if (r < 7'd60)
                k = 32'h8F1BBCDC;
            else
                k = 32'hCA62C1D6;
            return k;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            if (r < 7'd20)
                f = (b & c) | (~b & d);
            else if (r >= 7'd40 && r < 7'd60)
                f = (b & c) | (b & d) | (c & d);
            else
                f = b ^ c ^ d;
            return f;
        end
    endfunction
endpackage

// ----- rtl/sha1_front.sv -----
// Front part: input queue that decouples accepted words from the compression engine.
module sha1_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          msg_byte,
    input  logic                byte_valid,
    input  logic                msg_end,
    input  logic                valid,
    output logic                ready,
    output sha1_pkg::sha1_item_t item,
    output logic                item_valid,
    input  logic                item_take
);
    import sha1_pkg::*;

    sha1_item_t mem_reg [QUEUE_DEPTH];
    logic [$clog2(QUEUE_DEPTH)-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [$clog2(QUEUE_DEPTH):0]   count_reg;
    logic push, pop;

    // Idle words carry nothing and are dropped at the door.
    assign ready      = (count_reg != QUEUE_DEPTH[$clog2(QUEUE_DEPTH):0]);
    assign push       = valid && ready && (byte_valid || msg_end);
    assign pop        = item_take && item_valid;
    assign item_valid = (count_reg != '0);
    assign item       = mem_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= '{data: msg_byte, byte_valid: byte_valid, msg_end: msg_end};
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + {{$clog2(QUEUE_DEPTH){1'b0}}, push}
                                   - {{$clog2(QUEUE_DEPTH){1'b0}}, pop};
        end
    end
endmodule

// ----- rtl/sha1_core.sv -----
// Back part: block buffer, padding sequencer, 80-round compression and digest output.
module sha1_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha1_pkg::sha1_item_t item,
    input  logic                 item_valid,
    output logic                 item_take,
    output logic [31:0]          digest_word,
    output logic [2:0]           word_index,
    output logic                 last_word,
    output logic                 out_valid,
    input  logic                 out_ready
);
    import sha1_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ROUND, S_PAD, S_LEN, S_OUT} state_t;
    typedef enum logic [1:0] {R_BYTE, R_PAD, R_LEN} ret_t;

    state_t      state_reg;
    ret_t        ret_reg;
    logic [31:0] w_reg [16];
    logic [31:0] chain_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]  round_reg;
    logic [5:0]  fill_reg;
    logic [60:0] count_reg;
    logic [2:0]  len_idx_reg;
    logic [2:0]  out_idx_reg;
    logic        pend_end_reg;
    logic        pad_first_reg;

    logic [31:0] w_cur, t_val, w_new;
    logic [63:0] bits;
    logic [7:0]  put_val;
    logic        put;
    logic [6:0]  rnd;

    // The round in progress is one behind the counter, since count zero loads a to e.
    assign rnd = round_reg - 7'd1;

    // Schedule word: first 16 rounds read the buffer, later ones expand it.
    assign w_new = {w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]} << 1
                 | {31'd0, (w_reg[13][31] ^ w_reg[8][31] ^ w_reg[2][31] ^ w_reg[0][31])};
    assign w_cur = (rnd < 7'd16) ? w_reg[0] : w_new;
    assign t_val = {a_reg[26:0], a_reg[31:27]} + round_f(rnd, b_reg, c_reg, d_reg)
                 + e_reg + round_k(rnd) + w_cur;
    assign bits  = {count_reg, 3'b000};

    assign item_take   = (state_reg == S_IDLE) && item_valid;
    assign digest_word = chain_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'd4);
    assign out_valid   = (state_reg == S_OUT);

    // Byte that goes into the buffer this cycle, if any.
    always_comb
    begin
        put     = 1'b0;
        put_val = 8'h00;
        unique case (state_reg)
            S_IDLE:
            begin
                put     = item_valid && item.byte_valid;
                put_val = item.data;
            end
            S_PAD:
            begin
                put     = 1'b1;
                put_val = pad_first_reg ? 8'h80 : 8'h00;
            end
            S_LEN:
            begin
                put     = 1'b1;
                put_val = bits[8*(7-len_idx_reg) +: 8];
            end
            default:
            begin
                put     = 1'b0;
                put_val = 8'h00;
            end
        endcase
    end

    // Sequencer, buffer, working registers and chaining words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= R_BYTE;
            round_reg     <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            len_idx_reg   <= '0;
            out_idx_reg   <= '0;
            pend_end_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0; e_reg <= '0;
            for (int i = 0; i < 16; i++)
                w_reg[i] <= '0;
            for (int i = 0; i < 5; i++)
                chain_reg[i] <= H_INIT[i];
        end
        else
        begin
            // Shift the byte in; a full block starts the rounds.
            if (put)
            begin
                w_reg[fill_reg[5:2]] <= {w_reg[fill_reg[5:2]][23:0], put_val};
                fill_reg <= fill_reg + 6'd1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        if (item.byte_valid)
                            count_reg <= count_reg + 61'd1;
                        pend_end_reg  <= item.msg_end;
                        pad_first_reg <= 1'b1;
                        if (item.byte_valid && fill_reg == 6'd63)
                        begin
                            state_reg <= S_ROUND;
                            ret_reg   <= R_BYTE;
                        end
                        else if (item.msg_end)
                            state_reg <= S_PAD;
                    end
                end
                S_PAD:
                begin
                    pad_first_reg <= 1'b0;
                    if (fill_reg == 6'd63)
                    begin
                        state_reg <= S_ROUND;
                        ret_reg   <= R_PAD;
                    end
                    else if (fill_reg == 6'd55)
                    begin
                        state_reg   <= S_LEN;
                        len_idx_reg <= '0;
                    end
                end
                S_LEN:
                begin
                    len_idx_reg <= len_idx_reg + 3'd1;
                    if (len_idx_reg == 3'd7)
                    begin
                        state_reg <= S_ROUND;
                        ret_reg   <= R_LEN;
                    end
                end
                S_ROUND:
                begin
                    if (round_reg == 7'd0)
                    begin
                        a_reg <= chain_reg[0]; b_reg <= chain_reg[1];
                        c_reg <= chain_reg[2]; d_reg <= chain_reg[3];
                        e_reg <= chain_reg[4];
                        round_reg <= 7'd1;
                    end
                    else
                    begin
                        // Round round_reg-1 uses schedule word w_reg[0], then slides.
                        e_reg <= d_reg;
                        d_reg <= c_reg;
                        c_reg <= {b_reg[1:0], b_reg[31:2]};
                        b_reg <= a_reg;
                        a_reg <= t_val;
                        for (int i = 0; i < 15; i++)
                            w_reg[i] <= w_reg[i+1];
                        w_reg[15] <= w_cur;
                        if (round_reg == 7'd80)
                        begin
                            round_reg <= 7'd0;
                            chain_reg[0] <= chain_reg[0] + t_val;
                            chain_reg[1] <= chain_reg[1] + a_reg;
                            chain_reg[2] <= chain_reg[2] + {b_reg[1:0], b_reg[31:2]};
                            chain_reg[3] <= chain_reg[3] + c_reg;
                            chain_reg[4] <= chain_reg[4] + d_reg;
                            unique case (ret_reg)
                                R_BYTE:  state_reg <= pend_end_reg ? S_PAD : S_IDLE;
                                R_PAD:   state_reg <= S_PAD;
                                R_LEN:   state_reg <= S_OUT;
                                default: state_reg <= S_IDLE;
                            endcase
                            out_idx_reg <= '0;
                        end
                        else
                            round_reg <= round_reg + 7'd1;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd4)
                        begin
                            state_reg <= S_IDLE;
                            count_reg <= '0;
                            out_idx_reg <= '0;
                            for (int i = 0; i < 5; i++)
                                chain_reg[i] <= H_INIT[i];
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/sha1_message_digest.sv -----
// Top level of the SHA-1 digest block.
// Words carry one message byte each; a front queue of four words takes them while the
// compression engine works. The engine takes bytes only while it is idle; each full
// 64-byte block then runs through the single shared round unit before it takes more.
// An end word adds padding at one byte a cycle, one or two more compressions, and five
// digest words h0 to h4 offered one a cycle while out_ready is high; the chaining words
// then return to their initial values for the next message.
`include "sha1_message_digest_defines.svh"
module sha1_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  msg_byte,
    input  logic        byte_valid,
    input  logic        msg_end,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    output logic        out_valid,
    input  logic        out_ready
);
    import sha1_pkg::*;

    sha1_item_t item;
    logic       item_valid, item_take;

    // Front queue.
    sha1_front u_front (
        .clk(clk), .rst_n(rst_n), .msg_byte(msg_byte), .byte_valid(byte_valid),
        .msg_end(msg_end), .valid(in_valid), .ready(in_ready), .item(item),
        .item_valid(item_valid), .item_take(item_take)
    );

    // Compression engine.
    sha1_core u_core (
        .clk(clk), .rst_n(rst_n), .item(item), .item_valid(item_valid),
        .item_take(item_take), .digest_word(digest_word), .word_index(word_index),
        .last_word(last_word), .out_valid(out_valid), .out_ready(out_ready)
    );

    // Checks.
    `SHA1_ASSERT_IMPL(a_last_idx, clk, rst_n, out_valid && last_word, word_index == 3'd4)
    `SHA1_ASSERT_IMPL(a_idx_range, clk, rst_n, out_valid, word_index <= 3'd4)
    `SHA1_ASSERT_NEXT(a_idx_step, clk, rst_n, out_valid && out_ready && !last_word, out_valid && word_index == $past(word_index) + 3'd1)
endmodule
